>>> design/sorted_multiset_table_macros.svh
// Assertion macros for the sorted multiset table.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SORTED_MULTISET_TABLE_MACROS_SVH
`define SORTED_MULTISET_TABLE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SMT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SMT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/smt_pkg.sv
// Shared types and codes for the sorted multiset table.
// No dependencies; used by the interfaces and every module.
package smt_pkg;

  localparam int CMD_W = 2;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int LEN_W = 7;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [LEN_W-1:0] length;
    logic [LEN_W-1:0] removed_count;
  } smt_res_t;

endpackage

>>> design/smt_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on smt_pkg for field widths.
interface smt_in_if import smt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface smt_out_if import smt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [LEN_W-1:0] length;
  logic [LEN_W-1:0] removed_count;

  modport source (output valid, status, length, removed_count, input ready);
  modport sink   (input valid, status, length, removed_count, output ready);
endinterface

>>> design/sorted_multiset_table.sv
// Sorted multiset table: one command item in, one result item out.
// Clear, full insert and unused codes go straight to the result; delete reads every entry
// once and packs the kept ones down; insert walks down from the top, moving each larger entry
// up one slot; output stalls hold the result. Only one item is in flight at a time: the next
// is taken only after the result has been handed to the output register.
// Reset clears the length and control; memory contents are not cleared.
`include "sorted_multiset_table_macros.svh"

module sorted_multiset_table import smt_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  smt_in_if.sink    in_ch,
  smt_out_if.source out_ch
);

  smt_res_t res;
  logic     res_valid;
  logic     res_ready;

  logic             out_valid_r;
  logic [ST_W-1:0]  out_status_r;
  logic [LEN_W-1:0] out_length_r;
  logic [LEN_W-1:0] out_removed_r;
  logic             out_full;

  smt_seq #(.DEPTH(DEPTH)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .in_value  (in_ch.value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_status_r  <= res.status;
      out_length_r  <= res.length;
      out_removed_r <= res.removed_count;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.length        = out_length_r;
  assign out_ch.removed_count = out_removed_r;

  assign out_full = out_valid_r && (out_status_r == ST_FULL);

  `SMT_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "ready")
  `SMT_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result changed")
  `SMT_ASSERT_IMP(a_full_none_removed, out_full, out_removed_r == '0, "full with removal")

endmodule

>>> design/smt_store.sv
// Entry memory: one write port, one read port with registered read data.
// Depends on smt_pkg for the entry width.
module smt_store import smt_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic signed [VAL_W-1:0] wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic signed [VAL_W-1:0] rdata
);

  logic signed [VAL_W-1:0] mem_r [DEPTH];
  logic signed [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/smt_seq.sv
// Command sequencer: walks the entry memory to shift for insert and
// compact for delete. Depends on smt_pkg and smt_store.
module smt_seq import smt_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    res_valid,
  input  logic                    res_ready,
  output smt_res_t                res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_INS_RD  = 6'b000010,
    S_INS_CMP = 6'b000100,
    S_DEL_RD  = 6'b001000,
    S_DEL_CMP = 6'b010000,
    S_RES     = 6'b100000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           ptr_r, ptr_nxt;
  logic [CW-1:0]           wr_r, wr_nxt;
  logic [CW-1:0]           removed_r, removed_nxt;
  logic [ST_W-1:0]         status_r, status_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;

  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic signed [VAL_W-1:0] mem_wdata, mem_rdata;

  smt_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ptr_nxt     = ptr_r;
    wr_nxt      = wr_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    val_nxt     = val_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = AW'(ptr_r);
    mem_wdata   = val_r;
    mem_raddr   = AW'(ptr_r);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt     = in_value;
          status_nxt  = ST_OK;
          removed_nxt = '0;
          ptr_nxt     = '0;
          wr_nxt      = '0;
          state_nxt   = S_RES;
          case (in_cmd)
            CMD_INSERT: begin
              if (cnt_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                ptr_nxt   = cnt_r;
                state_nxt = S_INS_RD;
              end
            end
            CMD_DELETE: begin
              state_nxt = S_DEL_RD;
            end
            CMD_CLEAR: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                removed_nxt = cnt_r;
                cnt_nxt     = '0;
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_INS_RD: begin
        // ptr_r is the free slot; look at the entry just below it
        if (ptr_r == '0) begin
          mem_we    = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_RES;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(ptr_r - 1'b1);
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (mem_rdata > val_r) begin
          // move the larger entry up one slot and keep walking down
          mem_wdata = mem_rdata;
          ptr_nxt   = ptr_r - 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_RES;
        end
      end
      S_DEL_RD: begin
        if (ptr_r == cnt_r) begin
          removed_nxt = cnt_r - wr_r;
          cnt_nxt     = wr_r;
          status_nxt  = (cnt_r == wr_r) ? ST_ABSENT : ST_OK;
          state_nxt   = S_RES;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_DEL_CMP;
        end
      end
      S_DEL_CMP: begin
        // keep entries that differ, packing them down to the write pointer
        if (mem_rdata != val_r) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(wr_r);
          mem_wdata = mem_rdata;
          wr_nxt    = wr_r + 1'b1;
        end
        ptr_nxt   = ptr_r + 1'b1;
        state_nxt = S_DEL_RD;
      end
      S_RES: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    ptr_r     <= ptr_nxt;
    wr_r      <= wr_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
    val_r     <= val_nxt;
  end

  assign in_ready          = (state_r == S_IDLE);
  assign res_valid         = (state_r == S_RES);
  assign res.status        = status_r;
  assign res.length        = LEN_W'(cnt_r);
  assign res.removed_count = LEN_W'(removed_r);

endmodule

>>> test/tb_sorted_multiset_table.sv
// Testbench for sorted_multiset_table: random and directed command items checked against
// an in-bench model of the sorted table. Depends on smt_pkg, smt_in_if and smt_out_if.
module tb_sorted_multiset_table;
  import smt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 64;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int MAX_REPORTS = 50;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
    bit                      drain;  // hold this item until every result is back
  } cmd_item_t;

  logic clk;
  logic rst_n;

  smt_in_if  in_ch ();
  smt_out_if out_ch ();

  sorted_multiset_table #(.DEPTH(DEPTH)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  cmd_item_t               cmd_q[$];
  smt_res_t                result_q[$];
  logic signed [VAL_W-1:0] model_store [DEPTH];
  int                      model_len;
  logic signed [VAL_W-1:0] pool [8];
  int                      errors;
  int                      cycles;
  int                      send_gap;
  int                      recv_stall;
  bit                      in_took;
  bit                      calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s got %0d, want %0d", cycles, what, got, want);
  endtask

  // Apply one command to the table copy and return the result it must produce.
  task automatic predict_table_step(input logic [CMD_W-1:0] cmd,
                                    input logic signed [VAL_W-1:0] v,
                                    output smt_res_t r);
    int pos;
    int wr;
    int gone;
    logic [ST_W-1:0] st;
    st   = ST_OK;
    gone = 0;
    case (cmd)
      CMD_INSERT: begin
        if (model_len >= DEPTH) begin
          st = ST_FULL;
        end else begin
          pos = 0;
          while (pos < model_len && model_store[pos] <= v) pos++;
          for (int i = model_len; i > pos; i--) model_store[i] = model_store[i-1];
          model_store[pos] = v;
          model_len++;
        end
      end
      CMD_DELETE: begin
        wr = 0;
        for (int i = 0; i < model_len; i++) begin
          if (model_store[i] != v) begin
            model_store[wr] = model_store[i];
            wr++;
          end
        end
        gone      = model_len - wr;
        model_len = wr;
        if (gone == 0) st = ST_ABSENT;
      end
      CMD_CLEAR: begin
        if (model_len == 0) begin
          st = ST_EMPTY;
        end else begin
          gone      = model_len;
          model_len = 0;
        end
      end
      default: ;
    endcase
    r.status        = st;
    r.length        = model_len[LEN_W-1:0];
    r.removed_count = gone[LEN_W-1:0];
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [VAL_W-1:0] extreme_value();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return pool[$urandom_range(0, 7)];
    if (r < 90) return $urandom;
    return extreme_value();
  endfunction

  // Draw a fresh set of values so deletes keep hitting stored duplicates.
  task automatic refresh_pool();
    int r;
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) pool[i] = $signed($urandom_range(0, 40)) - 20;
      else if (r < 80) pool[i] = $urandom;
      else pool[i] = extreme_value();
    end
  endtask

  task automatic add_item(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] v,
                          input bit drain);
    cmd_item_t it;
    it.cmd   = cmd;
    it.value = v;
    it.drain = drain;
    cmd_q.push_back(it);
  endtask

  task automatic add_mixed(input int n, inout int made);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) add_item(CMD_INSERT, pick_value(), 1'b0);
      else if (r < 80) add_item(CMD_DELETE, pick_value(), 1'b0);
      else if (r < 88) add_item(CMD_DELETE, $urandom, 1'b0);
      else if (r < 94) add_item(CMD_CLEAR, $urandom, 1'b0);
      else add_item(CMD_UNUSED, $urandom, 1'b0);
      made++;
    end
  endtask

  task automatic build_stimulus();
    int made;
    int kind;
    int n;
    bit drain;
    logic signed [VAL_W-1:0] v;
    // Directed: empty-table cases, extremes, head insert, duplicates.
    add_item(CMD_CLEAR,  32'd0,         1'b0);
    add_item(CMD_DELETE, 32'd5,         1'b0);
    add_item(CMD_UNUSED, 32'hdead_beef, 1'b0);
    add_item(CMD_INSERT, 32'd0,         1'b0);
    add_item(CMD_INSERT, 32'h7fff_ffff, 1'b0);
    add_item(CMD_INSERT, 32'h8000_0000, 1'b0);
    add_item(CMD_INSERT, 32'hffff_ffff, 1'b0);
    add_item(CMD_INSERT, 32'd0,         1'b0);
    add_item(CMD_INSERT, 32'd0,         1'b0);
    add_item(CMD_DELETE, 32'd0,         1'b0);
    add_item(CMD_DELETE, 32'd12345,     1'b0);
    add_item(CMD_UNUSED, 32'h5555_aaaa, 1'b0);
    add_item(CMD_DELETE, 32'h8000_0000, 1'b0);
    add_item(CMD_DELETE, 32'h7fff_ffff, 1'b0);
    add_item(CMD_DELETE, 32'hffff_ffff, 1'b0);
    add_item(CMD_INSERT, 32'd7,         1'b0);
    add_item(CMD_INSERT, 32'd7,         1'b0);
    add_item(CMD_INSERT, 32'd3,         1'b0);
    add_item(CMD_INSERT, -32'sd9,       1'b0);
    add_item(CMD_CLEAR,  32'hffff_ffff, 1'b0);
    add_item(CMD_CLEAR,  32'd1,         1'b0);

    made  = 0;
    drain = 1'b1;
    while (made < RANDOM_ITEMS) begin
      refresh_pool();
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        // Fill to near or past capacity, then work on the near-full or full table.
        add_item(CMD_CLEAR, $urandom, drain);
        n = $urandom_range(62, 70);
        for (int i = 0; i < n; i++) add_item(CMD_INSERT, pick_value(), 1'b0);
        made += n + 1;
        add_mixed($urandom_range(5, 20), made);
      end else if (kind == 2) begin
        // One value fills the whole table, then a single delete takes it all.
        v = pick_value();
        add_item(CMD_CLEAR, $urandom, drain);
        n = $urandom_range(64, 66);
        for (int i = 0; i < n; i++) add_item(CMD_INSERT, v, 1'b0);
        add_item(CMD_DELETE, v, 1'b0);
        made += n + 2;
      end else begin
        if (drain) begin
          add_item(CMD_UNUSED, $urandom, 1'b1);
          made++;
        end
        add_mixed($urandom_range(15, 40), made);
      end
      drain = ($urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_INSERT;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    model_len    = 0;
    errors       = 0;
    send_gap     = 0;
    recv_stall   = 0;
    in_took      = 1'b0;
    build_stimulus();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() > 0 || in_ch.valid) @(posedge clk);
    while (result_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial cycles = 0;

  always @(posedge clk) calm <= ((cycles / 3000) % 4) == 3;

  // Predict on every accepted command item.
  always @(posedge clk) begin
    smt_res_t r;
    in_took <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_table_step(in_ch.cmd, in_ch.value, r);
      result_q.push_back(r);
    end
  end

  // Driver: present the front item, drop it once taken, then wait a random gap, which may be zero.
  always @(negedge clk) begin
    bit nv;
    if (rst_n) begin
      nv = in_ch.valid;
      if (in_ch.valid && in_took) begin
        void'(cmd_q.pop_front());
        nv       = 1'b0;
        send_gap = pick_gap();
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_q.size() > 0 && !(cmd_q[0].drain && result_q.size() > 0)) begin
          nv = 1'b1;
          in_ch.cmd   <= cmd_q[0].cmd;
          in_ch.value <= cmd_q[0].value;
        end
      end
      in_ch.valid <= nv;
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    bit rdy;
    if (recv_stall > 0) begin
      recv_stall--;
      rdy = 1'b0;
    end else begin
      rdy = rst_n;
      if (rst_n && !calm && $urandom_range(0, 7) == 0) recv_stall = pick_gap();
    end
    out_ch.ready <= rdy;
  end

  // Monitor: compare each accepted result item with the oldest prediction.
  always @(posedge clk) begin
    smt_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected result item, status", out_ch.status, -1);
      end else begin
        want = result_q.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
        if (out_ch.length !== want.length)
          report_mismatch("length", out_ch.length, want.length);
        if (out_ch.removed_count !== want.removed_count)
          report_mismatch("removed_count", out_ch.removed_count, want.removed_count);
      end
    end
  end

endmodule

>>> sim.f
+incdir+design
design/smt_pkg.sv
design/smt_if.sv
design/smt_store.sv
design/smt_seq.sv
design/sorted_multiset_table.sv
test/tb_sorted_multiset_table.sv
